// ----- hdl/mchb_pkg.sv -----
// Shared types, codes and sizes of the multi-channel history buffer.
package mchb_pkg;

   localparam int DEFAULT_CHANNELS  = 4;
   localparam int DEFAULT_MAX_DEPTH = 16;

   // A history request never emits more than this many transfers.
   localparam int RESULT_LIMIT = 16;

   localparam int FUNC_W      = 2;
   localparam int CHAN_W      = 2;
   localparam int SAMPLE_W    = 32;
   localparam int INDEX_W     = 8;
   localparam int TIME_W      = 32;
   localparam int STAMP_W     = 16;
   localparam int COUNT_W     = 5;
   localparam int DEPTH_REG_W = 5;
   localparam int ENABLE_W    = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int ENTRY_W     = STAMP_W + SAMPLE_W;
   localparam int RESULT_W    = $clog2(RESULT_LIMIT + 1);

   localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_HIST = 2'd2;

   localparam logic REG_DEPTH  = 1'b0;
   localparam logic REG_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_HIST
   } state_type;

endpackage

// ----- hdl/multi_channel_history_buffer.sv -----
// Top level of the multi-channel history buffer: control, channel state, entry RAM and result register.
//
//   channel   direction  handshake                      payload
//   request   in         start high, busy low           req_func .. req_now_seconds
//   response  out        rsp_valid for one cycle        rsp_value .. rsp_last
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An add does not raise busy; its result shows in the cycle after the transfer.
// A read passes the read state; a history request stays in the history state while it
// emits; each entry comes out of the entry RAM, whose registered read port yields one entry a cycle.
// A history request with nothing to emit and an unused function code leave the control idle.
// Synchronous reset empties every channel at once; the entry RAM needs no clearing.
// Results cannot be held off, so busy alone paces the requester.
module multi_channel_history_buffer #(
   parameter int CHANNELS  = mchb_pkg::DEFAULT_CHANNELS,
   parameter int MAX_DEPTH = mchb_pkg::DEFAULT_MAX_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic        [mchb_pkg::FUNC_W-1:0]      req_func,
   input  logic        [mchb_pkg::CHAN_W-1:0]      req_channel,
   input  logic signed [mchb_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic        [mchb_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic        [mchb_pkg::INDEX_W-1:0]     req_want_count,
   input  logic        [mchb_pkg::TIME_W-1:0]      req_now_seconds,
   output logic                                    rsp_valid,
   output logic signed [mchb_pkg::SAMPLE_W-1:0]    rsp_value,
   output logic        [mchb_pkg::STAMP_W-1:0]     rsp_stamp,
   output logic signed [mchb_pkg::TIME_W-1:0]      rsp_age,
   output logic        [mchb_pkg::COUNT_W-1:0]     rsp_stored_count,
   output logic                                    rsp_found,
   output logic                                    rsp_last,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic        [mchb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic        [mchb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic        [mchb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                    pready
);

   import mchb_pkg::*;

   localparam int FW       = $clog2(MAX_DEPTH + 1);
   localparam int PW       = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
   localparam int SW       = $clog2(2 * MAX_DEPTH);
   localparam int CH_W     = $clog2(CHANNELS > 1 ? CHANNELS : 2);
   localparam int SLOTS    = CHANNELS * MAX_DEPTH;
   localparam int AW       = $clog2(SLOTS > 1 ? SLOTS : 2);
   localparam int CLEAR_CH = CHANNELS < ENABLE_W ? CHANNELS : ENABLE_W;

   state_type st_ff, st_in;

   logic [DEPTH_REG_W-1:0] depth_ff, depth_in;
   logic [ENABLE_W-1:0]    enable_ff, enable_in;
   logic [FW-1:0]          fill_ff [CHANNELS];
   logic [FW-1:0]          fill_in [CHANNELS];
   logic [PW-1:0]          old_ff  [CHANNELS];
   logic [PW-1:0]          old_in  [CHANNELS];

   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [FW-1:0]       cur_fill_ff, cur_fill_in;
   logic [PW-1:0]       cur_old_ff, cur_old_in;
   logic [RESULT_W-1:0] n_ff, n_in;
   logic [RESULT_W-1:0] idx_ff, idx_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                hit_ff, hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic [TIME_W-1:0]   age_ff, age_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                found_ff, found_in;
   logic                last_ff, last_in;

   logic                accept, cfg_wr;
   logic [CH_W-1:0]     ch_ix;
   logic                ok;
   logic [FW-1:0]       live_fill;
   logic [PW-1:0]       live_old;
   logic [FW-1:0]       eff_depth;
   logic                full;
   logic [FW-1:0]       add_fill;
   logic [PW-1:0]       add_old;
   logic [PW-1:0]       add_pos;
   logic                rd_hit;
   logic [INDEX_W-1:0]  fill8, nsel;
   logic [RESULT_W-1:0] hist_n;
   logic                hist_go;
   logic                hist_last;

   logic [CH_W-1:0]     sel_ch;
   logic [FW-1:0]       sel_fill;
   logic [PW-1:0]       sel_old;
   logic [SW-1:0]       sel_i;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic [SAMPLE_W-1:0] rd_sample;
   logic [STAMP_W-1:0]  rd_stamp;

   // Ring positions stay below twice the depth, so one subtract brings them back.
   function automatic logic [PW-1:0] wrap(input logic [SW-1:0] p);
      if (32'(p) >= MAX_DEPTH) begin
         return PW'(p - SW'(MAX_DEPTH));
      end
      return PW'(p);
   endfunction

   function automatic logic [AW-1:0] slot(input logic [CH_W-1:0] c, input logic [PW-1:0] p);
      return AW'(AW'(c) * AW'(MAX_DEPTH) + AW'(p));
   endfunction

   assign accept    = start && !busy;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_ENABLE) ? CSR_DATA_W'(enable_ff)
                                               : CSR_DATA_W'(depth_ff);

   assign ch_ix     = CH_W'(req_channel);
   assign ok        = (32'(req_channel) < CHANNELS) && enable_ff[req_channel];
   assign live_fill = ok ? fill_ff[ch_ix] : '0;
   assign live_old  = ok ? old_ff[ch_ix] : '0;

   always_comb begin
      if (32'(depth_ff) > MAX_DEPTH) begin
         eff_depth = FW'(MAX_DEPTH);
      end else if (depth_ff == '0) begin
         eff_depth = FW'(1);
      end else begin
         eff_depth = FW'(depth_ff);
      end
   end

   // When the channel is full (or over a lowered depth) the oldest entries are dropped.
   // The newest slot is oldest plus count in either case.
   assign full     = live_fill >= eff_depth;
   assign add_fill = full ? eff_depth : live_fill + FW'(1);
   assign add_old  = full ? wrap(SW'(live_old) + SW'(live_fill) - SW'(eff_depth) + SW'(1))
                          : live_old;
   assign add_pos  = wrap(SW'(live_old) + SW'(live_fill));

   assign rd_hit    = ok && (req_entry_index < INDEX_W'(live_fill));
   assign fill8     = INDEX_W'(live_fill);
   assign nsel      = (req_want_count < fill8) ? req_want_count : fill8;
   assign hist_n    = (32'(nsel) > RESULT_LIMIT) ? RESULT_W'(RESULT_LIMIT) : RESULT_W'(nsel);
   assign hist_go   = ok && (hist_n != '0);
   assign hist_last = idx_ff == n_ff - RESULT_W'(1);

   assign ram_waddr = slot(ch_ix, add_pos);
   assign ram_wdata = {req_now_seconds[STAMP_W-1:0], req_sample};
   assign rd_sample = ram_rdata[SAMPLE_W-1:0];
   assign rd_stamp  = ram_rdata[ENTRY_W-1:SAMPLE_W];

   mchb_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_entries (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_READ) begin
               st_in = ST_READ;
            end else if (accept && req_func == FUNC_HIST && hist_go) begin
               st_in = ST_HIST;
            end
         end
         ST_READ: st_in = ST_IDLE;
         ST_HIST: begin
            if (hist_last) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // State outputs: busy and the RAM read address.
   always_comb begin
      busy     = 1'b1;
      sel_ch   = ch_ix;
      sel_fill = live_fill;
      sel_old  = live_old;
      sel_i    = '0;
      case (st_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_func == FUNC_READ) begin
               sel_i = SW'(req_entry_index);
            end
         end
         ST_HIST: begin
            sel_ch   = ch_ff;
            sel_fill = cur_fill_ff;
            sel_old  = cur_old_ff;
            sel_i    = SW'(idx_ff) + SW'(1);
         end
         default: ;
      endcase
      ram_raddr = slot(sel_ch, wrap(SW'(sel_old) + SW'(sel_fill) - SW'(1) - sel_i));
   end

   // Datapath next values.
   always_comb begin
      depth_in     = depth_ff;
      enable_in    = enable_ff;
      fill_in      = fill_ff;
      old_in       = old_ff;
      ch_in        = ch_ff;
      cur_fill_in  = cur_fill_ff;
      cur_old_in   = cur_old_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      value_in     = value_ff;
      stamp_in     = stamp_ff;
      age_in       = age_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      ram_we       = 1'b0;

      if (cfg_wr) begin
         case (paddr[2])
            REG_DEPTH: depth_in = pwdata[DEPTH_REG_W-1:0];
            REG_ENABLE: begin
               enable_in = pwdata[ENABLE_W-1:0];
               // A channel that is switched on starts out empty.
               for (int c = 0; c < CLEAR_CH; c++) begin
                  if (pwdata[c] && !enable_ff[c]) begin
                     fill_in[c] = '0;
                     old_in[c]  = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in       = ch_ix;
               cur_fill_in = live_fill;
               cur_old_in  = live_old;
               now_in      = req_now_seconds;
               hit_in      = rd_hit;
               n_in        = hist_n;
               idx_in      = '0;
               if (req_func == FUNC_ADD) begin
                  rsp_valid_in = 1'b1;
                  last_in      = 1'b1;
                  age_in       = '0;
                  found_in     = ok;
                  if (ok) begin
                     ram_we          = 1'b1;
                     fill_in[ch_ix]  = add_fill;
                     old_in[ch_ix]   = add_old;
                     value_in        = req_sample;
                     stamp_in        = req_now_seconds[STAMP_W-1:0];
                     count_in        = COUNT_W'(add_fill);
                  end else begin
                     value_in = '0;
                     stamp_in = '0;
                     count_in = '0;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            value_in     = hit_ff ? rd_sample : '0;
            stamp_in     = hit_ff ? rd_stamp : '0;
            age_in       = '0;
            count_in     = COUNT_W'(cur_fill_ff);
            found_in     = hit_ff;
            last_in      = 1'b1;
         end
         ST_HIST: begin
            rsp_valid_in = 1'b1;
            value_in     = rd_sample;
            stamp_in     = rd_stamp;
            age_in       = now_ff - TIME_W'(rd_stamp);
            count_in     = COUNT_W'(cur_fill_ff);
            found_in     = 1'b1;
            last_in      = hist_last;
            idx_in       = idx_ff + RESULT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         depth_ff     <= DEPTH_RESET;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            fill_ff[c] <= '0;
            old_ff[c]  <= '0;
         end
      end else begin
         st_ff        <= st_in;
         depth_ff     <= depth_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         old_ff       <= old_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      cur_fill_ff <= cur_fill_in;
      cur_old_ff  <= cur_old_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      hit_ff      <= hit_in;
      value_ff    <= value_in;
      stamp_ff    <= stamp_in;
      age_ff      <= age_in;
      count_ff    <= count_in;
      found_ff    <= found_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_stamp        = stamp_ff;
   assign rsp_age          = age_ff;
   assign rsp_stored_count = count_ff;
   assign rsp_found        = found_ff;
   assign rsp_last         = last_ff;

`ifndef ASSERT_OFF
   // A read transfer yields exactly one final result through the read state and the result register.
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_READ |=> ##1 rsp_valid && rsp_last)
      else $error("read transfer did not produce its result");

   // A history request with entries to emit enters the emit loop.
   a_hist_enter: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_HIST && hist_go |=> st_ff == ST_HIST)
      else $error("history request did not start emitting");

   // The emit loop never runs past the clipped count or on an empty channel.
   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_HIST |-> idx_ff < n_ff && cur_fill_ff != '0)
      else $error("history index ran past its count");

   // The last history entry goes out as the final result of its request.
   a_hist_end: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_HIST && hist_last |=> rsp_valid && rsp_last)
      else $error("history did not end cleanly");
`endif

endmodule

// ----- hdl/mchb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mchb_ram #(
   parameter int WIDTH = mchb_pkg::ENTRY_W,
   parameter int DEPTH = mchb_pkg::DEFAULT_CHANNELS * mchb_pkg::DEFAULT_MAX_DEPTH,
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
